FILE: hw/rtl/nfc_pkg.sv
// Shared constants and types for the NOR flash command controller.
`timescale 1ns / 1ps
package nfc_pkg;

  // Array geometry; both sizes are powers of two
  localparam int ARRAY_WORDS  = 1048576;
  localparam int SECTOR_WORDS = 32768;
  localparam int ARRAY_AW     = $clog2(ARRAY_WORDS);
  localparam int SECTOR_AW    = $clog2(SECTOR_WORDS);
  localparam logic [ARRAY_AW-1:0] LAST_WORD = ARRAY_AW'(ARRAY_WORDS - 1);

  // Bus field widths
  localparam int ADDR_W      = 21;
  localparam int DATA_W      = 16;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_IDX_W   = 2;

  // Word index one past the array end
  localparam logic [ADDR_W-1:0] ARRAY_END = ADDR_W'(ARRAY_WORDS);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CMD_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CMD_SECOND = 2'd1;

  localparam logic [ADDR_W-1:0] CMD_FIRST_RST  = 21'h000AAA;
  localparam logic [ADDR_W-1:0] CMD_SECOND_RST = 21'h000554;

  // Command words and fixed read values
  localparam logic [DATA_W-1:0] CMD_UNLOCK1  = 16'h00AA;
  localparam logic [DATA_W-1:0] CMD_UNLOCK2  = 16'h0055;
  localparam logic [DATA_W-1:0] CMD_PROGRAM  = 16'h00A0;
  localparam logic [DATA_W-1:0] CMD_ERASE    = 16'h0080;
  localparam logic [DATA_W-1:0] CMD_SECTOR   = 16'h0030;
  localparam logic [DATA_W-1:0] STATUS_WORD  = 16'h0040;
  localparam logic [DATA_W-1:0] ERASED_WORD  = 16'hFFFF;

  // What the command decoder asks of the datapath for the current beat
  typedef struct packed {
    logic prog_wr;
    logic erase_go;
    logic status_rd;
  } nfc_act_t;

endpackage

FILE: hw/rtl/nfc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module nfc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/nfc_cmd.sv
// Command buffer, unlock sequence detection, operating mode and status-read count.
`timescale 1ns / 1ps
module nfc_cmd (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic                         is_write,
  input  logic [nfc_pkg::ADDR_W-1:0]   addr,
  input  logic [nfc_pkg::DATA_W-1:0]   data,
  input  logic                         in_range,
  input  logic [nfc_pkg::ADDR_W-1:0]   cmd_first,
  input  logic [nfc_pkg::ADDR_W-1:0]   cmd_second,
  output nfc_pkg::nfc_act_t            act
);
  import nfc_pkg::*;

  typedef enum logic [2:0] {
    MODE_READ    = 3'b001,
    MODE_PROGRAM = 3'b010,
    MODE_ERASE   = 3'b100
  } mode_t;

  logic [DATA_W-1:0] buf_r   [5];
  logic [DATA_W-1:0] buf_nxt [5];
  logic [2:0]        idx_r, idx_nxt;
  mode_t             mode_r, mode_nxt;
  logic              status_r, status_nxt;
  logic              is_cmd;
  logic              take;
  logic              prog_seq;
  logic              erase_seq;

  // Classify the beat against the current mode
  assign is_cmd = (addr == cmd_first) || (addr == cmd_second);
  assign take   = is_write && is_cmd && (mode_r != MODE_PROGRAM);

  assign act.status_rd = !is_write && (mode_r != MODE_READ);
  assign act.prog_wr   = is_write && (mode_r == MODE_PROGRAM) && in_range;
  assign act.erase_go  = is_write && !is_cmd && (mode_r == MODE_ERASE) &&
                         (data == CMD_SECTOR) && in_range;

  // Buffer with the new command word in place, for sequence matching
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      buf_nxt[i] = buf_r[i];
    end
    if (take) begin
      buf_nxt[idx_r] = data;
    end
  end

  assign prog_seq  = (buf_nxt[0] == CMD_UNLOCK1) && (buf_nxt[1] == CMD_UNLOCK2) &&
                     (buf_nxt[2] == CMD_PROGRAM);
  assign erase_seq = (buf_nxt[0] == CMD_UNLOCK1) && (buf_nxt[1] == CMD_UNLOCK2) &&
                     (buf_nxt[2] == CMD_ERASE) && (buf_nxt[3] == CMD_UNLOCK1) &&
                     (buf_nxt[4] == CMD_UNLOCK2);

  // Next mode, index and status count
  always_comb begin
    idx_nxt    = idx_r;
    mode_nxt   = mode_r;
    status_nxt = status_r;
    if (take) begin
      idx_nxt = idx_r + 3'd1;
      if (prog_seq) begin
        mode_nxt = MODE_PROGRAM;
        idx_nxt  = 3'd0;
      end else if (erase_seq) begin
        mode_nxt = MODE_ERASE;
        idx_nxt  = 3'd0;
      end else if (idx_nxt == 3'd5) begin
        idx_nxt = 3'd0;
      end
    end
    // Second status read returns to read mode
    if (act.status_rd) begin
      if (status_r) begin
        status_nxt = 1'b0;
        mode_nxt   = MODE_READ;
      end else begin
        status_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= 3'd0;
      mode_r   <= MODE_READ;
      status_r <= 1'b0;
      for (int i = 0; i < 5; i++) begin
        buf_r[i] <= '0;
      end
    end else if (accept) begin
      idx_r    <= idx_nxt;
      mode_r   <= mode_nxt;
      status_r <= status_nxt;
      // Drop the matched words once a sequence is recognized
      for (int i = 0; i < 5; i++) begin
        if (take && prog_seq && i < 3) begin
          buf_r[i] <= '0;
        end else if (take && !prog_seq && erase_seq) begin
          buf_r[i] <= '0;
        end else begin
          buf_r[i] <= buf_nxt[i];
        end
      end
    end
  end

endmodule

FILE: hw/rtl/nor_flash_command_controller.sv
// Top level of the NOR flash command controller: bus beats, array RAM and erase walker.
// A write beat's result is registered from the accepted beat; a read first passes through
// ST_READ, where the registered array data becomes the result. A new beat waits for the
// previous result to be taken, so no beat is accepted while a result is pending.
// A sector erase walks the shared address counter over the sector, one word per cycle;
// the next beat is taken only after the sector's last word has been written.
// Reset (rst_n, synchronous) starts a clearing pass over the whole array that sets it
// to 0xFFFF; beats are held off meanwhile, configuration writes are taken at once.
`timescale 1ns / 1ps
module nor_flash_command_controller (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: byte_address[20:0], write_data[36:21], zero pad [39:37]
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [nfc_pkg::IN_TDATA_W-1:0]   in_tdata,
  // in_tuser: func (0 read, 1 write)
  input  logic                             in_tuser,
  // out_tdata: read_data[15:0]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [nfc_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // out_tuser: addr_error
  output logic                             out_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [nfc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nfc_pkg::ADDR_W-1:0]       cfg_data
);
  import nfc_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_ERASE = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [ARRAY_AW-1:0] walk_r, walk_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [DATA_W-1:0]   out_data_r, out_data_nxt;
  logic                out_err_r, out_err_nxt;
  logic                rd_status_r, rd_status_nxt;
  logic                rd_err_r, rd_err_nxt;
  logic [ADDR_W-1:0]   cmd_first_r;
  logic [ADDR_W-1:0]   cmd_second_r;

  logic                accept;
  logic                is_write;
  logic [ADDR_W-1:0]   addr;
  logic [DATA_W-1:0]   wdata;
  logic [ADDR_W-2:0]   word;
  logic                in_range;
  logic                walking;
  logic                walk_last;
  nfc_act_t            act;

  logic                ram_we;
  logic [ARRAY_AW-1:0] ram_waddr;
  logic [DATA_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [DATA_W-1:0]   ram_rdata;

  // Unpack the input beat
  assign is_write = in_tuser;
  assign addr     = in_tdata[ADDR_W-1:0];
  assign wdata    = in_tdata[ADDR_W+DATA_W-1:ADDR_W];
  assign word     = addr[ADDR_W-1:1];
  assign in_range = {1'b0, word} < ARRAY_END;

  assign in_tready = (state_r == ST_IDLE) && !out_tvalid_r;
  assign accept    = in_tvalid && in_tready;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_first_r  <= CMD_FIRST_RST;
      cmd_second_r <= CMD_SECOND_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CMD_FIRST:  cmd_first_r  <= cfg_data;
        REG_CMD_SECOND: cmd_second_r <= cfg_data;
        default: ;
      endcase
    end
  end

  nfc_cmd u_cmd (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .is_write   (is_write),
    .addr       (addr),
    .data       (wdata),
    .in_range   (in_range),
    .cmd_first  (cmd_first_r),
    .cmd_second (cmd_second_r),
    .act        (act)
  );

  // Shared address walker: clearing pass and sector erase
  assign walking   = (state_r == ST_CLEAR) || (state_r == ST_ERASE);
  assign walk_last = (walk_r == LAST_WORD) ||
                     ((state_r == ST_ERASE) && (&walk_r[SECTOR_AW-1:0]));

  // Array port selection
  assign ram_we    = walking || (accept && act.prog_wr);
  assign ram_waddr = walking ? walk_r : word[ARRAY_AW-1:0];
  assign ram_wdata = walking ? ERASED_WORD : wdata;
  assign ram_re    = accept && !is_write && !act.status_rd && in_range;

  nfc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (ARRAY_WORDS)
  ) u_array (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (word[ARRAY_AW-1:0]),
    .rdata (ram_rdata)
  );

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    walk_nxt       = walk_r;
    out_tvalid_nxt = out_tvalid_r;
    out_data_nxt   = out_data_r;
    out_err_nxt    = out_err_r;
    rd_status_nxt  = rd_status_r;
    rd_err_nxt     = rd_err_r;
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    case (state_r)
      ST_CLEAR, ST_ERASE: begin
        walk_nxt = walk_r + ARRAY_AW'(1);
        if (walk_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (!is_write) begin
            rd_status_nxt = act.status_rd;
            rd_err_nxt    = !in_range;
            state_nxt     = ST_READ;
          end else begin
            out_tvalid_nxt = 1'b1;
            out_data_nxt   = '0;
            out_err_nxt    = !in_range;
            if (act.erase_go) begin
              walk_nxt  = {word[ARRAY_AW-1:SECTOR_AW], {SECTOR_AW{1'b0}}};
              state_nxt = ST_ERASE;
            end
          end
        end
      end
      ST_READ: begin
        out_tvalid_nxt = 1'b1;
        out_err_nxt    = rd_err_r;
        if (rd_status_r) begin
          out_data_nxt = STATUS_WORD;
        end else if (rd_err_r) begin
          out_data_nxt = '0;
        end else begin
          out_data_nxt = ram_rdata;
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      walk_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      walk_r       <= walk_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    out_err_r   <= out_err_nxt;
    rd_status_r <= rd_status_nxt;
    rd_err_r    <= rd_err_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_err_r;

  // A read beat always moves into the read-data state
  a_read_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !is_write) |=> (state_r == ST_READ))
    else $error("read beat did not enter read state");

  // The walker steps one word a cycle until it reaches its end
  a_walk_step: assert property (@(posedge clk) disable iff (!rst_n)
    (walking && !walk_last) |=> (walk_r == $past(walk_r) + ARRAY_AW'(1)))
    else $error("address walker skipped a word");

  // No result is raised while the array is being swept
  a_no_out_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (walking && !out_tvalid_r) |=> !out_tvalid_r)
    else $error("result raised during array sweep");

  // An accepted write is answered in the next cycle
  a_write_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_write) |=> out_tvalid_r)
    else $error("write beat got no result");

endmodule
